// ===== src/palette_ramdac_pixel_expander_defines.svh =====
// ----------------------------------------------------------------------------
// Palette RAMDAC pixel expander - assertion macros
// Shared property wrappers; define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef PALETTE_RAMDAC_PIXEL_EXPANDER_DEFINES_SVH
`define PALETTE_RAMDAC_PIXEL_EXPANDER_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define CHK_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

`define CHK_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define CHK_IMPLY(lbl, clk, rst_n, ante, cons)

`define CHK_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== src/prpe_pkg.sv =====
// ----------------------------------------------------------------------------
// Palette RAMDAC pixel expander - package
// Shared types, codes and helpers for the front end, queue and back end.
// ----------------------------------------------------------------------------
`default_nettype none

package prpe_pkg;

    localparam logic [2:0] MODE_PIXEL   = 3'd0;
    localparam logic [2:0] MODE_ADDR_WR = 3'd1;
    localparam logic [2:0] MODE_DATA_WR = 3'd2;
    localparam logic [2:0] MODE_ADDR_RD = 3'd3;
    localparam logic [2:0] MODE_DATA_RD = 3'd4;

    localparam logic [2:0] DEPTH_1BPP  = 3'd0;
    localparam logic [2:0] DEPTH_2BPP  = 3'd1;
    localparam logic [2:0] DEPTH_4BPP  = 3'd2;
    localparam logic [2:0] DEPTH_8BPP  = 3'd3;
    localparam logic [2:0] DEPTH_X555  = 3'd4;
    localparam logic [2:0] DEPTH_24BPP = 3'd5;

    localparam logic [1:0] REG_DEPTH_MODE     = 2'd0;
    localparam logic [1:0] REG_PALETTE_LOCK   = 2'd1;
    localparam logic [1:0] REG_MONO_MONITOR   = 2'd2;
    localparam logic [1:0] REG_DISPLAY_ENABLE = 2'd3;

    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;
    localparam logic [1:0] CH_NONE  = 2'd3;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QUEUE_AW    = 1;
    localparam int unsigned QUEUE_CW    = 2;

    localparam int unsigned OUT_DEPTH = 4;
    localparam int unsigned OUT_AW    = 2;
    localparam int unsigned OUT_CW    = 3;

    typedef struct packed {
        logic [2:0] depth_mode;
        logic       palette_lock;
        logic       mono_monitor;
        logic       display_enable;
    } cfg_t;

    typedef enum logic [1:0] {
        CMD_PIXEL,
        CMD_PAL_WR,
        CMD_ADDR_RD,
        CMD_DATA_RD
    } cmd_kind_t;

    typedef enum logic [1:0] {
        SRC_PALETTE,
        SRC_DIRECT,
        SRC_ADDR,
        SRC_CHANNEL
    } src_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [2:0]  depth;
        logic [31:0] word;
        logic [7:0]  data;
        logic [7:0]  slot;
        logic [2:0]  wmask;
        logic [1:0]  chsel;
    } cmd_t;

    typedef struct packed {
        logic       last;
        logic [7:0] read_byte;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } out_t;

    function automatic logic [7:0] pal_mod(input logic [7:0] idx, input logic [8:0] n);
        logic [11:0] r;
        logic [11:0] m;
        r = {4'd0, idx};
        for (int k = 3; k >= 0; k--)
        begin
            m = {3'd0, n} << k;
            if (r >= m)
            begin
                r = r - m;
            end
        end
        return r[7:0];
    endfunction

endpackage

`default_nettype wire

// ===== src/prpe_ram.sv =====
// ----------------------------------------------------------------------------
// Palette RAMDAC pixel expander - generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module prpe_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== src/prpe_front.sv =====
// ----------------------------------------------------------------------------
// Palette RAMDAC pixel expander - front end
// Accepts items, tracks palette address and channel index, emits commands.
// ----------------------------------------------------------------------------
`default_nettype none

module prpe_front #(
    parameter int unsigned PALETTE_ENTRIES = 256
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           s_axis_tvalid,
    output logic                s_axis_tready,
    input  wire logic [39:0]    s_axis_tdata,   // pixel_word[31:0], write_byte[39:32]
    input  wire logic [2:0]     s_axis_tuser,   // mode[2:0]
    input  wire prpe_pkg::cfg_t cfg,
    input  wire logic           q_full,
    output logic                push,
    output prpe_pkg::cmd_t      cmd
);

    import prpe_pkg::*;

    localparam logic [8:0] PAL_N = 9'(PALETTE_ENTRIES);

    logic [7:0]  ptr_reg;
    logic [7:0]  ptr_next;
    logic [7:0]  chan_reg;
    logic [7:0]  chan_next;
    logic [7:0]  chan_inc;
    logic        accept;
    logic [2:0]  mode;
    logic [31:0] word;
    logic [7:0]  wb;
    logic [2:0]  wmask;

    assign s_axis_tready = !q_full;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign mode          = s_axis_tuser;
    assign word          = s_axis_tdata[31:0];
    assign wb            = s_axis_tdata[39:32];
    assign chan_inc      = chan_reg + 8'd1;

    always_comb
    begin
        wmask = 3'b000;
        if (cfg.mono_monitor)
        begin
            if (chan_reg == 8'd2)
            begin
                wmask = 3'b111;
            end
        end
        else if (chan_reg < 8'd3)
        begin
            wmask = 3'b001 << chan_reg[1:0];
        end
    end

    always_comb
    begin
        ptr_next   = ptr_reg;
        chan_next  = chan_reg;
        push       = 1'b0;
        cmd.kind   = CMD_PIXEL;
        cmd.depth  = cfg.depth_mode;
        cmd.word   = word;
        cmd.data   = wb;
        cmd.slot   = pal_mod(ptr_reg, PAL_N);
        cmd.wmask  = wmask;
        cmd.chsel  = (chan_reg < 8'd3) ? chan_reg[1:0] : CH_NONE;
        if (accept)
        begin
            unique case (mode)
                MODE_PIXEL:
                begin
                    push = (cfg.depth_mode <= DEPTH_24BPP);
                end
                MODE_ADDR_WR:
                begin
                    ptr_next  = wb;
                    chan_next = 8'd0;
                end
                MODE_DATA_WR:
                begin
                    if (!cfg.palette_lock)
                    begin
                        cmd.kind  = CMD_PAL_WR;
                        push      = (wmask != 3'b000);
                        chan_next = chan_inc;
                        if (chan_inc == 8'd4)
                        begin
                            chan_next = 8'd0;
                            ptr_next  = ptr_reg + 8'd1;
                        end
                    end
                end
                MODE_ADDR_RD:
                begin
                    cmd.kind  = CMD_ADDR_RD;
                    cmd.data  = ptr_reg;
                    push      = 1'b1;
                    chan_next = 8'd0;
                end
                MODE_DATA_RD:
                begin
                    cmd.kind  = CMD_DATA_RD;
                    push      = 1'b1;
                    chan_next = chan_inc;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg  <= 8'd0;
            chan_reg <= 8'd0;
        end
        else
        begin
            ptr_reg  <= ptr_next;
            chan_reg <= chan_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/prpe_queue.sv =====
// ----------------------------------------------------------------------------
// Palette RAMDAC pixel expander - command queue
// Short FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module prpe_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire prpe_pkg::cmd_t push_cmd,
    output logic                full,
    input  wire logic           pop,
    output logic                empty,
    output prpe_pkg::cmd_t      head
);

    import prpe_pkg::*;

    cmd_t                mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_reg;
    logic [QUEUE_AW-1:0] wr_next;
    logic [QUEUE_AW-1:0] rd_reg;
    logic [QUEUE_AW-1:0] rd_next;
    logic [QUEUE_CW-1:0] cnt_reg;
    logic [QUEUE_CW-1:0] cnt_next;

    assign full  = (cnt_reg == QUEUE_CW'(QUEUE_DEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = mem_reg[rd_reg];

    always_comb
    begin
        wr_next  = push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + QUEUE_CW'(push) - QUEUE_CW'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/prpe_back.sv =====
// ----------------------------------------------------------------------------
// Palette RAMDAC pixel expander - back end
// Runs commands: pixel unpack, palette access, result FIFO to the stream.
// ----------------------------------------------------------------------------
`default_nettype none
`include "palette_ramdac_pixel_expander_defines.svh"

module prpe_back #(
    parameter int unsigned PALETTE_ENTRIES = 256
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           display_enable,
    input  wire logic           q_empty,
    input  wire prpe_pkg::cmd_t head,
    output logic                pop,
    output logic                m_axis_tvalid,
    input  wire logic           m_axis_tready,
    output logic [31:0]         m_axis_tdata,   // red[7:0], green[15:8], blue[23:16],
                                                // read_byte[31:24]
    output logic                m_axis_tlast
);

    import prpe_pkg::*;

    localparam int unsigned AW    = $clog2(PALETTE_ENTRIES);
    localparam logic [8:0]  PAL_N = 9'(PALETTE_ENTRIES);

    logic              busy_reg;
    logic              busy_next;
    cmd_t              cur_reg;
    cmd_t              cur_next;
    logic [31:0]       sh_reg;
    logic [31:0]       sh_next;
    logic [5:0]        cnt_reg;
    logic [5:0]        cnt_next;

    logic              clr_busy_reg;
    logic [AW-1:0]     clr_addr_reg;

    logic              cur_pix;
    logic              cur_wr;
    logic              room;
    logic              fire;
    logic              last_op;
    logic              done;
    logic              issue_out;
    logic [5:0]        bpp_amt;
    logic [7:0]        pix_idx;
    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     wr_addr;
    logic [2:0]        wr_en;
    logic [7:0]        wr_data;
    src_t              src;
    logic [23:0]       direct_rgb;

    logic [7:0]        ram_r;
    logic [7:0]        ram_g;
    logic [7:0]        ram_b;
    logic [7:0]        pal_r;
    logic [7:0]        pal_g;
    logic [7:0]        pal_b;

    logic              s2_vld_reg;
    src_t              s2_src_reg;
    logic [23:0]       s2_direct_reg;
    logic [7:0]        s2_byte_reg;
    logic [1:0]        s2_chsel_reg;
    logic              s2_last_reg;
    out_t              res;

    out_t              o_mem_reg [OUT_DEPTH];
    logic [OUT_AW-1:0] o_wr_reg;
    logic [OUT_AW-1:0] o_rd_reg;
    logic [OUT_CW-1:0] ocnt_reg;
    logic [OUT_CW-1:0] ocnt_next;
    logic              o_pop;
    out_t              o_head;

    // issue stage
    assign cur_pix   = (cur_reg.kind == CMD_PIXEL);
    assign cur_wr    = (cur_reg.kind == CMD_PAL_WR);
    assign room      = ((ocnt_reg + OUT_CW'(s2_vld_reg)) < OUT_CW'(OUT_DEPTH));
    assign fire      = busy_reg && (cur_wr || room);
    assign last_op   = !cur_pix || (cnt_reg == 6'd1);
    assign done      = fire && last_op;
    assign issue_out = fire && !cur_wr;
    assign pop       = !clr_busy_reg && !q_empty && (!busy_reg || done);
    assign bpp_amt   = 6'd1 << cur_reg.depth;

    always_comb
    begin
        unique case (cur_reg.depth)
            DEPTH_1BPP: pix_idx = {sh_reg[31], 7'h7f};
            DEPTH_2BPP: pix_idx = {sh_reg[31:30], 6'h3f};
            DEPTH_4BPP: pix_idx = {sh_reg[31:28], 4'h0f};
            default:    pix_idx = sh_reg[31:24];
        endcase
    end

    always_comb
    begin
        if (cur_reg.depth == DEPTH_X555)
        begin
            direct_rgb = {sh_reg[30:26], 3'b000, sh_reg[25:21], 3'b000,
                          sh_reg[20:16], 3'b000};
        end
        else
        begin
            direct_rgb = sh_reg[23:0];
        end
    end

    always_comb
    begin
        unique case (cur_reg.kind)
            CMD_PIXEL:   src = (cur_reg.depth <= DEPTH_8BPP) ? SRC_PALETTE : SRC_DIRECT;
            CMD_PAL_WR:  src = SRC_ADDR;
            CMD_ADDR_RD: src = SRC_ADDR;
            CMD_DATA_RD: src = SRC_CHANNEL;
        endcase
    end

    // clear the palette to black after reset, then take writes from commands
    assign rd_addr = cur_pix ? AW'(pal_mod(pix_idx, PAL_N)) : cur_reg.slot[AW-1:0];
    assign wr_addr = clr_busy_reg ? clr_addr_reg : cur_reg.slot[AW-1:0];
    assign wr_data = clr_busy_reg ? 8'd0 : cur_reg.data;
    assign wr_en   = clr_busy_reg ? 3'b111 :
                     ((fire && cur_wr) ? cur_reg.wmask : 3'b000);

    always_comb
    begin
        busy_next = busy_reg;
        cur_next  = cur_reg;
        sh_next   = sh_reg;
        cnt_next  = cnt_reg;
        if (pop)
        begin
            busy_next = 1'b1;
            cur_next  = head;
            sh_next   = head.word;
            cnt_next  = 6'd32 >> head.depth;
        end
        else
        begin
            if (done)
            begin
                busy_next = 1'b0;
            end
            if (fire && cur_pix)
            begin
                sh_next  = sh_reg << bpp_amt;
                cnt_next = cnt_reg - 6'd1;
            end
        end
    end

    // palette storage, one RAM per channel
    prpe_ram #(.WIDTH(8), .DEPTH(PALETTE_ENTRIES)) u_ram_red (
        .clk   (clk),
        .we    (wr_en[0]),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (ram_r)
    );

    prpe_ram #(.WIDTH(8), .DEPTH(PALETTE_ENTRIES)) u_ram_green (
        .clk   (clk),
        .we    (wr_en[1]),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (ram_g)
    );

    prpe_ram #(.WIDTH(8), .DEPTH(PALETTE_ENTRIES)) u_ram_blue (
        .clk   (clk),
        .we    (wr_en[2]),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (ram_b)
    );

    // result stage
    assign pal_r = ram_r;
    assign pal_g = ram_g;
    assign pal_b = ram_b;

    always_comb
    begin
        res.last      = s2_last_reg;
        res.red       = 8'd0;
        res.green     = 8'd0;
        res.blue      = 8'd0;
        res.read_byte = 8'd0;
        unique case (s2_src_reg)
            SRC_PALETTE:
            begin
                if (display_enable)
                begin
                    res.red   = pal_r;
                    res.green = pal_g;
                    res.blue  = pal_b;
                end
            end
            SRC_DIRECT:
            begin
                if (display_enable)
                begin
                    res.red   = s2_direct_reg[23:16];
                    res.green = s2_direct_reg[15:8];
                    res.blue  = s2_direct_reg[7:0];
                end
            end
            SRC_ADDR:
            begin
                res.read_byte = s2_byte_reg;
            end
            SRC_CHANNEL:
            begin
                unique case (s2_chsel_reg)
                    CH_RED:   res.read_byte = pal_r;
                    CH_GREEN: res.read_byte = pal_g;
                    CH_BLUE:  res.read_byte = pal_b;
                    CH_NONE:  res.read_byte = 8'd0;
                endcase
            end
        endcase
    end

    // output FIFO
    assign o_head        = o_mem_reg[o_rd_reg];
    assign m_axis_tvalid = (ocnt_reg != '0);
    assign o_pop         = m_axis_tvalid && m_axis_tready;
    assign m_axis_tdata  = {o_head.read_byte, o_head.blue, o_head.green, o_head.red};
    assign m_axis_tlast  = o_head.last;
    assign ocnt_next     = ocnt_reg + OUT_CW'(s2_vld_reg) - OUT_CW'(o_pop);

    always_ff @(posedge clk)
    begin
        sh_reg        <= sh_next;
        cnt_reg       <= cnt_next;
        s2_direct_reg <= direct_rgb;
        s2_byte_reg   <= cur_reg.data;
        s2_chsel_reg  <= cur_reg.chsel;
        s2_last_reg   <= last_op;
        if (s2_vld_reg)
        begin
            o_mem_reg[o_wr_reg] <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            cur_reg      <= '0;
            s2_src_reg   <= SRC_PALETTE;
            s2_vld_reg   <= 1'b0;
            o_wr_reg     <= '0;
            o_rd_reg     <= '0;
            ocnt_reg     <= '0;
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else
        begin
            busy_reg   <= busy_next;
            cur_reg    <= cur_next;
            s2_src_reg <= src;
            s2_vld_reg <= issue_out;
            ocnt_reg   <= ocnt_next;
            if (s2_vld_reg)
            begin
                o_wr_reg <= o_wr_reg + 1'b1;
            end
            if (o_pop)
            begin
                o_rd_reg <= o_rd_reg + 1'b1;
            end
            if (clr_busy_reg)
            begin
                if (clr_addr_reg == AW'(PALETTE_ENTRIES - 1))
                begin
                    clr_busy_reg <= 1'b0;
                end
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
        end
    end

    `CHK_IMPLY(a_no_out_overflow, clk, rst_n, s2_vld_reg, ocnt_reg != OUT_CW'(OUT_DEPTH))
    `CHK_NEXT(a_issue_lands, clk, rst_n, issue_out, s2_vld_reg)
    `CHK_IMPLY(a_pixel_count_live, clk, rst_n, busy_reg && cur_pix, cnt_reg != 6'd0)
    `CHK_IMPLY(a_idle_while_clearing, clk, rst_n, clr_busy_reg, !busy_reg)

endmodule

`default_nettype wire

// ===== src/palette_ramdac_pixel_expander.sv =====
// ----------------------------------------------------------------------------
// Palette RAMDAC pixel expander - top level
// Palette RAM with packed-pixel unpacker and palette set-up access.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries items: tuser = mode, tdata = {write_byte, pixel_word}.
//   m_axis carries results: tdata = {read_byte, blue, green, red}; tlast
//   marks the final result of an item.
//   cfg_* writes depth_mode, palette_lock, mono_monitor, display_enable;
//   cfg_ready is always high. Write only while the block is idle.
// Path: an accepted item passes the command queue, the issue register, the
//   result stage and the result FIFO before its first result is valid on m_axis.
// Throughput: one result per cycle while m_axis_tready is high, limited by the
//   shared palette read address. A pixel word gives 32 >> depth_mode results
//   (one at 24 bpp), a palette read one. Address and data writes produce nothing.
// Reset: address and channel index clear, all config registers clear
//   (display off, 1 bpp); the palette is cleared to black by a pass over
//   all PALETTE_ENTRIES entries, during which commands wait in the queue.
// Stall: the result FIFO fills, the back end halts, the two-entry command
//   queue fills, and then s_axis_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module palette_ramdac_pixel_expander #(
    parameter int unsigned PALETTE_ENTRIES = 256
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // pixel_word[31:0], write_byte[39:32]
    input  wire logic [2:0]  s_axis_tuser,   // mode[2:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // red[7:0], green[15:8], blue[23:16],
                                             // read_byte[31:24]
    output logic             m_axis_tlast,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [2:0]  cfg_data
);

    import prpe_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic q_full;
    logic q_empty;
    logic q_push;
    logic q_pop;
    cmd_t q_in;
    cmd_t q_head;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_DEPTH_MODE:     cfg_next.depth_mode     = cfg_data;
                REG_PALETTE_LOCK:   cfg_next.palette_lock   = cfg_data[0];
                REG_MONO_MONITOR:   cfg_next.mono_monitor   = cfg_data[0];
                REG_DISPLAY_ENABLE: cfg_next.display_enable = cfg_data[0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    prpe_front #(.PALETTE_ENTRIES(PALETTE_ENTRIES)) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .cfg           (cfg_reg),
        .q_full        (q_full),
        .push          (q_push),
        .cmd           (q_in)
    );

    prpe_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_in),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .head     (q_head)
    );

    prpe_back #(.PALETTE_ENTRIES(PALETTE_ENTRIES)) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .display_enable (cfg_reg.display_enable),
        .q_empty        (q_empty),
        .head           (q_head),
        .pop            (q_pop),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tlast   (m_axis_tlast)
    );

endmodule

`default_nettype wire
